@@ hdl/bmphdr_pkg.sv @@
package bmphdr_pkg;

   typedef enum logic [1:0] {
      CMD_RESTART = 2'd0,
      CMD_BYTE    = 2'd1,
      CMD_QUERY   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_SIG    = 3'd1,
      ST_PLANES     = 3'd2,
      ST_DEPTH      = 3'd3,
      ST_COMPRESSED = 3'd4,
      ST_NO_HEADER  = 3'd5
   } status_type;

   typedef enum logic {
      KIND_VERDICT = 1'b0,
      KIND_ROW     = 1'b1
   } kind_type;

   localparam logic [15:0] SIG_VALUE = 16'h4D42;
   localparam logic [15:0] PLANES_ONE = 16'd1;
   localparam logic [15:0] DEPTH_24 = 16'd24;
   localparam logic [15:0] DEPTH_32 = 16'd32;
   localparam logic [2:0] BPP_FOUR = 3'd4;

   // index of the last byte of each header field
   localparam logic [5:0] IDX_SIG = 6'd1;
   localparam logic [5:0] IDX_OFFSET = 6'd13;
   localparam logic [5:0] IDX_WIDTH = 6'd21;
   localparam logic [5:0] IDX_HEIGHT = 6'd25;
   localparam logic [5:0] IDX_PLANES = 6'd27;
   localparam logic [5:0] IDX_DEPTH = 6'd29;
   localparam logic [5:0] IDX_COMP = 6'd33;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  header_byte;
      logic [15:0] row;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      status_type         status;
      logic [31:0]        image_width;
      logic signed [31:0] image_height;
      logic [2:0]         bytes_per_pixel;
      logic [33:0]        bytes_per_row;
      logic [31:0]        pixel_offset;
      logic [31:0]        row_address;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        data_offset;
      logic [31:0]        width;
      logic signed [31:0] height;
      logic [2:0]         pixel_bytes;
      logic [33:0]        row_stride;
   } hdr_type;

endpackage

@@ hdl/bmp_header_parse_row_address_core.sv @@
// an accepted req beat reaches the rsp beat through an input reg and a result reg
// throughput: one req beat per cycle while a stalled rsp beat does not hold it back; restarts,
//   unused commands and most bytes give no rsp beat, queries and a header-ending byte give one
// reset: synchronous, active high; clears the parse state, stored header, source_x
//   and both pipeline valids
module bmp_header_parse_row_address_core
   import bmphdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic        s1_valid_ff, s1_valid_in;
   req_type     req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [15:0] source_x_ff;

   logic [5:0]  byte_count_ff, byte_count_in;
   logic        verdict_ff, verdict_in;
   logic        hdr_valid_ff, hdr_valid_in;
   logic [31:0] acc_ff, acc_in;
   hdr_type     hdr_ff, hdr_in;

   logic        produce;
   logic        advance;
   logic [15:0] half;
   logic [33:0] raw_stride;
   logic [31:0] row_address;

   bmphdr_addr u_addr (
      .hdr         (hdr_ff),
      .source_x    (source_x_ff),
      .row         (req_ff.row),
      .row_address (row_address)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign advance = s1_valid_ff && (!produce || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_comb begin
      byte_count_in = byte_count_ff;
      verdict_in = verdict_ff;
      hdr_valid_in = hdr_valid_ff;
      acc_in = acc_ff;
      hdr_in = hdr_ff;
      rsp_in = '0;
      produce = 1'b0;
      half = acc_ff[31:16];
      raw_stride = '0;
      if (s1_valid_ff) begin
         case (req_ff.cmd)
            CMD_RESTART: begin
               byte_count_in = '0;
               verdict_in = 1'b0;
               hdr_valid_in = 1'b0;
               acc_in = '0;
               hdr_in = '0;
            end
            CMD_BYTE: begin
               if (!verdict_ff) begin
                  byte_count_in = byte_count_ff + 6'd1;
                  acc_in = {req_ff.header_byte, acc_ff[31:8]};
                  half = acc_in[31:16];
                  rsp_in.kind = KIND_VERDICT;
                  case (byte_count_ff)
                     IDX_SIG: begin
                        if (half != SIG_VALUE) begin
                           produce = 1'b1;
                           rsp_in.status = ST_BAD_SIG;
                        end
                     end
                     IDX_OFFSET: hdr_in.data_offset = acc_in;
                     IDX_WIDTH:  hdr_in.width = acc_in;
                     IDX_HEIGHT: hdr_in.height = acc_in;
                     IDX_PLANES: begin
                        if (half != PLANES_ONE) begin
                           produce = 1'b1;
                           rsp_in.status = ST_PLANES;
                        end
                     end
                     IDX_DEPTH: begin
                        if ((half == DEPTH_24) || (half == DEPTH_32)) begin
                           hdr_in.pixel_bytes = half[5:3];
                        end else begin
                           produce = 1'b1;
                           rsp_in.status = ST_DEPTH;
                        end
                     end
                     IDX_COMP: begin
                        produce = 1'b1;
                        if (acc_in != 32'd0) begin
                           rsp_in.status = ST_COMPRESSED;
                        end else begin
                           // width times 3 or 4, rounded up to a multiple of four
                           if (hdr_ff.pixel_bytes == BPP_FOUR) begin
                              raw_stride = {hdr_ff.width, 2'b00};
                           end else begin
                              raw_stride = {2'b00, hdr_ff.width} + {1'b0, hdr_ff.width, 1'b0};
                           end
                           raw_stride = raw_stride + 34'd3;
                           hdr_in.row_stride = {raw_stride[33:2], 2'b00};
                           hdr_valid_in = 1'b1;
                           rsp_in.status = ST_OK;
                           rsp_in.image_width = hdr_in.width;
                           rsp_in.image_height = hdr_in.height;
                           rsp_in.bytes_per_pixel = hdr_in.pixel_bytes;
                           rsp_in.bytes_per_row = hdr_in.row_stride;
                           rsp_in.pixel_offset = hdr_in.data_offset;
                        end
                     end
                     default: ;
                  endcase
                  if (produce) begin
                     verdict_in = 1'b1;
                  end
               end
            end
            CMD_QUERY: begin
               produce = 1'b1;
               rsp_in.kind = KIND_ROW;
               if (hdr_valid_ff) begin
                  rsp_in.status = ST_OK;
                  rsp_in.image_width = hdr_ff.width;
                  rsp_in.image_height = hdr_ff.height;
                  rsp_in.bytes_per_pixel = hdr_ff.pixel_bytes;
                  rsp_in.bytes_per_row = hdr_ff.row_stride;
                  rsp_in.pixel_offset = hdr_ff.data_offset;
                  rsp_in.row_address = row_address;
               end else begin
                  rsp_in.status = ST_NO_HEADER;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (advance && produce) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         source_x_ff <= '0;
         byte_count_ff <= '0;
         verdict_ff <= 1'b0;
         hdr_valid_ff <= 1'b0;
         acc_ff <= '0;
         hdr_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            source_x_ff <= csr_data;
         end
         if (advance) begin
            byte_count_ff <= byte_count_in;
            verdict_ff <= verdict_in;
            hdr_valid_ff <= hdr_valid_in;
            acc_ff <= acc_in;
            hdr_ff <= hdr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (advance && produce) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ hdl/bmphdr_addr.sv @@
module bmphdr_addr
   import bmphdr_pkg::*;
(
   input  hdr_type     hdr,
   input  logic [15:0] source_x,
   input  logic [15:0] row,
   output logic [31:0] row_address
);

   logic [31:0] lines;
   logic [31:0] row_offset;
   logic [18:0] col_offset;

   always_comb begin
      // positive height means rows are stored bottom-up
      if (!hdr.height[31] && (hdr.height != 32'sd0)) begin
         lines = 32'(hdr.height) - {16'b0, row} - 32'd1;
      end else begin
         lines = {16'b0, row};
      end
      row_offset = lines * hdr.row_stride[31:0];
      col_offset = 19'(source_x) * 19'(hdr.pixel_bytes);
      row_address = hdr.data_offset + row_offset + 32'(col_offset);
   end

endmodule

@@ hdl/bmphdr_checker.sv @@
module bmphdr_checker
   import bmphdr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled rsp beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // a good verdict carries a supported depth and a padded stride
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_VERDICT) && (rsp_data.status == ST_OK)
      |-> ((rsp_data.bytes_per_pixel == 3'd3) || (rsp_data.bytes_per_pixel == 3'd4))
          && (rsp_data.bytes_per_row[1:0] == 2'b00) && (rsp_data.row_address == 32'd0))
      else $error("bad fields in ok verdict");

   // failed verdicts and queries without a header show only the status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK)
      |-> (rsp_data.image_width == 32'd0) && (rsp_data.image_height == 32'sd0)
          && (rsp_data.bytes_per_pixel == 3'd0) && (rsp_data.bytes_per_row == 34'd0)
          && (rsp_data.pixel_offset == 32'd0) && (rsp_data.row_address == 32'd0))
      else $error("nonzero fields in error beat");

   // verdicts never claim a missing header; answers never claim a header error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.kind == KIND_ROW)
                     && ((rsp_data.status == ST_OK) || (rsp_data.status == ST_NO_HEADER)))
                 || ((rsp_data.kind == KIND_VERDICT) && (rsp_data.status != ST_NO_HEADER)))
      else $error("status does not fit beat kind");

endmodule

bind bmp_header_parse_row_address_core bmphdr_checker u_bmphdr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ test/bmp_header_parse_row_address_core_tb.sv @@
`timescale 1ns / 100ps

module bmp_header_parse_row_address_core_tb;
   import bmphdr_pkg::*;

   localparam cmd_type CMD_UNUSED = cmd_type'(2'd3);
   localparam int RSP_LATENCY = 2;
   localparam int BEATS_PER_PHASE = 240;
   localparam int HDR_BYTES = 34;

   typedef struct packed {
      logic [15:0] sig;
      logic [31:0] offset;
      logic [31:0] width;
      logic [31:0] height;
      logic [15:0] planes;
      logic [15:0] depth;
      logic [31:0] comp;
      logic [15:0] col;
   } bmp_fields_type;

   typedef struct packed {
      req_type beat;
      logic    typed;
      rsp_type want;
   } beat_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int live_beats = 0;

   rsp_type expected_rsp[$];

   // predicted parser state
   logic [5:0]  hdr_count;
   logic        verdict_out;
   logic        hdr_ok;
   logic [31:0] shift_acc;
   logic [31:0] pix_offset;
   logic [31:0] img_width;
   logic [31:0] img_height;
   logic [2:0]  pix_bytes;
   logic [34:0] stride;
   logic [15:0] src_x;
   logic        beat_ignored;

   beat_step_type  beat_table [17];
   bmp_fields_type header_table [8];

   bmp_header_parse_row_address_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("bmp_header_parse_row_address_core_tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   function automatic rsp_type status_only(kind_type k, status_type s);
      rsp_type o;
      o = '0;
      o.kind = k;
      o.status = s;
      return o;
   endfunction

   function automatic rsp_type stored_fields(kind_type k, logic [31:0] addr);
      rsp_type o;
      o = '0;
      o.kind = k;
      o.status = ST_OK;
      o.image_width = img_width;
      o.image_height = img_height;
      o.bytes_per_pixel = pix_bytes;
      o.bytes_per_row = stride[33:0];
      o.pixel_offset = pix_offset;
      o.row_address = addr;
      return o;
   endfunction

   function automatic void clear_header();
      hdr_count = '0;
      verdict_out = 1'b0;
      hdr_ok = 1'b0;
      shift_acc = '0;
      pix_offset = '0;
      img_width = '0;
      img_height = '0;
      pix_bytes = '0;
      stride = '0;
   endfunction

   function automatic bit header_fail(input status_type s, output rsp_type o);
      verdict_out = 1'b1;
      hdr_ok = 1'b0;
      o = status_only(KIND_VERDICT, s);
      return 1'b1;
   endfunction

   function automatic bit parse_beat(input req_type r, output rsp_type o);
      logic [5:0]  idx;
      logic [15:0] half;
      logic [31:0] lines;
      logic [31:0] addr;
      o = '0;
      beat_ignored = 1'b0;
      case (r.cmd)
         CMD_RESTART: begin
            clear_header();
            return 1'b0;
         end
         CMD_BYTE: begin
            if (verdict_out) begin
               beat_ignored = 1'b1;
               return 1'b0;
            end
            idx = hdr_count;
            hdr_count = hdr_count + 6'd1;
            shift_acc = {r.header_byte, shift_acc[31:8]};
            half = shift_acc[31:16];
            case (idx)
               IDX_SIG: if (half != SIG_VALUE) return header_fail(ST_BAD_SIG, o);
               IDX_OFFSET: pix_offset = shift_acc;
               IDX_WIDTH: img_width = shift_acc;
               IDX_HEIGHT: img_height = shift_acc;
               IDX_PLANES: if (half != PLANES_ONE) return header_fail(ST_PLANES, o);
               IDX_DEPTH: begin
                  // depth / 8
                  if (half == DEPTH_24 || half == DEPTH_32) pix_bytes = half[5:3];
                  else return header_fail(ST_DEPTH, o);
               end
               IDX_COMP: begin
                  if (shift_acc != '0) return header_fail(ST_COMPRESSED, o);
                  stride = (35'(img_width) * pix_bytes + 35'd3) & ~35'd3;
                  verdict_out = 1'b1;
                  hdr_ok = 1'b1;
                  o = stored_fields(KIND_VERDICT, '0);
                  return 1'b1;
               end
               default: ;
            endcase
            return 1'b0;
         end
         CMD_QUERY: begin
            if (!hdr_ok) begin
               o = status_only(KIND_ROW, ST_NO_HEADER);
               return 1'b1;
            end
            // positive height means rows stored bottom-up
            if (img_height != '0 && !img_height[31])
               lines = img_height - 32'(r.row) - 32'd1;
            else
               lines = 32'(r.row);
            addr = pix_offset + lines * stride[31:0] + src_x * pix_bytes;
            o = stored_fields(KIND_ROW, addr);
            return 1'b1;
         end
         default: begin
            beat_ignored = 1'b1;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("rsp beat with nothing expected: %0h", rsp_data);
            mismatches++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("kind", want.kind, rsp_data.kind);
            check_field("status", want.status, rsp_data.status);
            check_field("image_width", want.image_width, rsp_data.image_width);
            check_field("image_height", want.image_height, rsp_data.image_height);
            check_field("bytes_per_pixel", want.bytes_per_pixel, rsp_data.bytes_per_pixel);
            check_field("bytes_per_row", want.bytes_per_row, rsp_data.bytes_per_row);
            check_field("pixel_offset", want.pixel_offset, rsp_data.pixel_offset);
            check_field("row_address", want.row_address, rsp_data.row_address);
         end
      end
   end

   task automatic send_beat(input req_type r, input logic typed = 1'b0,
                            input rsp_type want = '0);
      rsp_type predicted;
      bit      has_rsp;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has_rsp = parse_beat(r, predicted);
      if (!beat_ignored) live_beats++;
      if (has_rsp) expected_rsp.push_back(typed ? want : predicted);
   endtask

   task automatic send_restart();
      send_beat(req_type'{CMD_RESTART, 8'($urandom), 16'($urandom)});
   endtask

   task automatic send_header(input bmp_fields_type f, input int nbytes);
      logic [8*HDR_BYTES-1:0] image;
      // byte 0 in the low bits; file size, creator and dib size are don't-care
      image = {f.comp, f.depth, f.planes, f.height, f.width, 32'($urandom),
               f.offset, 32'($urandom), 32'($urandom), f.sig};
      for (int i = 0; i < nbytes; i++)
         send_beat(req_type'{CMD_BYTE, image[8*i +: 8], 16'($urandom)});
   endtask

   task automatic send_queries(input int n);
      logic [15:0] row;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 2))
            0: row = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1: row = 16'($urandom_range(0, 15));
            default: row = 16'($urandom);
         endcase
         send_beat(req_type'{CMD_QUERY, 8'($urandom), row});
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2 * RSP_LATENCY) @(posedge clock);
   endtask

   task automatic write_source_x(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      src_x = v;
   endtask

   function automatic logic [31:0] pick_size(input int lo, input int hi);
      return ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(lo, hi));
   endfunction

   function automatic bmp_fields_type good_fields();
      bmp_fields_type f;
      f.sig = SIG_VALUE;
      f.offset = pick_size(0, 2048);
      f.width = pick_size(1, 4000);
      case ($urandom_range(0, 3))
         0: f.height = 32'($urandom_range(1, 600));
         1: f.height = -32'($urandom_range(1, 600));
         2: f.height = '0;
         default: f.height = 32'($urandom);
      endcase
      f.planes = PLANES_ONE;
      f.depth = $urandom_range(0, 1) ? DEPTH_24 : DEPTH_32;
      f.comp = '0;
      f.col = '0;
      return f;
   endfunction

   function automatic bmp_fields_type broken_fields();
      bmp_fields_type f;
      f = good_fields();
      case ($urandom_range(0, 3))
         0: f.sig = 16'($urandom);
         1: f.planes = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
         2: f.depth = $urandom_range(0, 1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
         default: f.comp = $urandom_range(0, 1) ? 32'd1 << $urandom_range(0, 31)
                                                : 32'($urandom);
      endcase
      return f;
   endfunction

   task automatic random_step();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick <= 10) begin
         if ($urandom_range(0, 9) != 0) send_restart();
         send_header(good_fields(), HDR_BYTES);
         send_queries($urandom_range(1, 6));
      end else if (pick <= 13) begin
         send_restart();
         send_header(broken_fields(), HDR_BYTES);
         send_queries($urandom_range(1, 2));
      end else if (pick <= 15) begin
         send_restart();
         send_header(good_fields(), $urandom_range(1, HDR_BYTES - 1));
         send_queries(1);
      end else begin
         send_beat(req_type'{cmd_type'(2'($urandom)), 8'($urandom), 16'($urandom)});
      end
   endtask

   initial begin
      src_x = '0;
      clear_header();

      beat_table = '{
         '{req_type'{CMD_QUERY, 8'h00, 16'h0000}, 1'b1, status_only(KIND_ROW, ST_NO_HEADER)},
         '{req_type'{CMD_QUERY, 8'hFF, 16'hFFFF}, 1'b1, status_only(KIND_ROW, ST_NO_HEADER)},
         '{req_type'{CMD_UNUSED, 8'hFF, 16'hFFFF}, 1'b0, '0},
         '{req_type'{CMD_BYTE, 8'h42, 16'h0000}, 1'b0, '0},
         '{req_type'{CMD_BYTE, 8'h00, 16'h0000}, 1'b1, status_only(KIND_VERDICT, ST_BAD_SIG)},
         '{req_type'{CMD_BYTE, 8'hFF, 16'h0000}, 1'b0, '0},
         '{req_type'{CMD_QUERY, 8'h00, 16'h1234}, 1'b1, status_only(KIND_ROW, ST_NO_HEADER)},
         '{req_type'{CMD_RESTART, 8'hFF, 16'hFFFF}, 1'b0, '0},
         '{req_type'{CMD_BYTE, 8'h00, 16'hFFFF}, 1'b0, '0},
         '{req_type'{CMD_BYTE, 8'h4D, 16'hFFFF}, 1'b1, status_only(KIND_VERDICT, ST_BAD_SIG)},
         '{req_type'{CMD_RESTART, 8'h00, 16'h0000}, 1'b0, '0},
         '{req_type'{CMD_BYTE, 8'h42, 16'h0000}, 1'b0, '0},
         '{req_type'{CMD_BYTE, 8'h4D, 16'h0000}, 1'b0, '0},
         // restart after a good signature, in the middle of a header
         '{req_type'{CMD_RESTART, 8'h00, 16'h0000}, 1'b0, '0},
         '{req_type'{CMD_QUERY, 8'h00, 16'h0001}, 1'b1, status_only(KIND_ROW, ST_NO_HEADER)},
         '{req_type'{CMD_BYTE, 8'hFF, 16'h0000}, 1'b0, '0},
         '{req_type'{CMD_BYTE, 8'hFF, 16'h0000}, 1'b1, status_only(KIND_VERDICT, ST_BAD_SIG)}
      };

      header_table = '{
         '{SIG_VALUE, 32'd54, 32'd1, 32'd1, PLANES_ONE, DEPTH_24, 32'd0, 16'h0000},
         '{SIG_VALUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, PLANES_ONE, DEPTH_32,
           32'd0, 16'hFFFF},
         '{SIG_VALUE, 32'd0, 32'd3, 32'hFFFF_FFFE, PLANES_ONE, DEPTH_24, 32'd0, 16'h0001},
         '{SIG_VALUE, 32'd138, 32'd100, 32'd0, PLANES_ONE, DEPTH_32, 32'd0, 16'hFFFF},
         '{SIG_VALUE, 32'd54, 32'hFFFF_FFFF, 32'h8000_0000, PLANES_ONE, DEPTH_24,
           32'd0, 16'h0000},
         '{SIG_VALUE, 32'd54, 32'd8, 32'd8, 16'd0, DEPTH_24, 32'd0, 16'h0000},
         '{SIG_VALUE, 32'd54, 32'd8, 32'd8, PLANES_ONE, 16'hFFFF, 32'd0, 16'h0000},
         '{SIG_VALUE, 32'd54, 32'd8, 32'd8, PLANES_ONE, DEPTH_32, 32'hFFFF_FFFF, 16'h0000}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (beat_table[i])
         send_beat(beat_table[i].beat, beat_table[i].typed, beat_table[i].want);

      // full headers at the field extremes and with bad planes, depth or compression, source_x changed while idle
      foreach (header_table[i]) begin
         drain();
         write_source_x(header_table[i].col);
         send_restart();
         send_header(header_table[i], HDR_BYTES);
         send_beat(req_type'{CMD_QUERY, 8'h00, 16'h0000});
         send_beat(req_type'{CMD_QUERY, 8'hFF, 16'hFFFF});
      end

      for (int phase = 0; phase < 3; phase++) begin
         int target;
         drain();
         write_source_x(16'($urandom));
         case (phase)
            0: begin
               send_idle_pct = 8;
               recv_idle_pct = 76;
            end
            1: begin
               send_idle_pct = 76;
               recv_idle_pct = 8;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         target = live_beats + BEATS_PER_PHASE;
         while (live_beats < target) random_step();
      end

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4 * RSP_LATENCY) @(posedge clock);
      if (mismatches == 0)
         $display("bmp_header_parse_row_address_core_tb: clean");
      else
         $display("bmp_header_parse_row_address_core_tb: errors");
      $finish;
   end

endmodule
